FILE: rtl/pdnf_pkg.sv
// ----------------------------------------------------------------------------
// pdnf_pkg
// Shared types and defaults for the point deque with nearest and farthest
// search.
// ----------------------------------------------------------------------------
`default_nettype none

package pdnf_pkg;

    localparam int CAPACITY_DEF   = 8;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_COUNT      = 3'd4,
        ACT_CLEAR      = 3'd5,
        ACT_FARTHEST   = 3'd6,
        ACT_NEAREST    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What a storage cell loads at the next edge.
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PREV = 2'd1,
        OP_NEXT = 2'd2,
        OP_NEW  = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQ,
        S_SCAN
    } fsm_state_t;

endpackage

`default_nettype wire

FILE: rtl/pdnf_cell.sv
// ----------------------------------------------------------------------------
// pdnf_cell
// One storage cell of the deque row: holds one point with its squared
// distance and loads from either neighbor or from the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pdnf_cell #(
    parameter int ENTRY_W = 80
) (
    input  wire                          clk,
    input  wire  pdnf_pkg::cell_op_t     op,
    input  wire  [ENTRY_W-1:0]           prev_in,
    input  wire  [ENTRY_W-1:0]           next_in,
    input  wire  [ENTRY_W-1:0]           new_in,
    output logic [ENTRY_W-1:0]           q
);

    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;

    always_comb
    begin
        case (op)
            pdnf_pkg::OP_HOLD: data_next = data_reg;
            pdnf_pkg::OP_PREV: data_next = prev_in;
            pdnf_pkg::OP_NEXT: data_next = next_in;
            pdnf_pkg::OP_NEW:  data_next = new_in;
            default:           data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

FILE: rtl/pdnf_sqdist.sv
// ----------------------------------------------------------------------------
// pdnf_sqdist
// Squared distance from the origin, one coordinate per cycle through a
// single multiplier and an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pdnf_sqdist #(
    parameter int COORD_BITS = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire  signed [COORD_BITS-1:0]   px,
    input  wire  signed [COORD_BITS-1:0]   py,
    input  wire  signed [COORD_BITS-1:0]   pz,
    output logic        [2*COORD_BITS-1:0] sum_sq,
    output logic                           done
);

    localparam int DIST_W = 2 * COORD_BITS;

    logic              run_reg;
    logic              run_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              done_reg;
    logic              done_next;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] acc_next;

    logic signed [COORD_BITS-1:0] comp;
    logic        [COORD_BITS-1:0] mag;
    logic        [DIST_W-1:0]     sq;

    always_comb
    begin
        case (step_reg)
            2'd0:    comp = px;
            2'd1:    comp = py;
            default: comp = pz;
        endcase
    end

    // The magnitude of the most negative value still fits as unsigned.
    assign mag = comp[COORD_BITS-1] ? (~comp + COORD_BITS'(1)) : comp;
    assign sq  = DIST_W'(mag) * DIST_W'(mag);

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = 2'd0;
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            acc_next  = acc_reg + sq;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign sum_sq = acc_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

FILE: rtl/point_deque_nearest_farthest.sv
// ----------------------------------------------------------------------------
// point_deque_nearest_farthest
// Bounded deque of signed 3-D points with nearest and farthest search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// the result ports for exactly one cycle with done high, and must be captured
// then. Count, clear and both pops answer in the cycle after the request and
// leave busy low, so one such request can follow every cycle. A push builds
// the squared distance of the new point one coordinate per cycle in a single
// multiplier and stores it with the point. A nearest or farthest search
// rotates the row of cells once all the way round, comparing the front cell
// with the best so far in each cycle. Refused requests (push when full, pop or
// search when empty) answer in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module point_deque_nearest_farthest #(
    parameter int CAPACITY   = pdnf_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = pdnf_pkg::COORD_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  [2:0]                           action,
    input  wire  signed [COORD_BITS-1:0]         coord_x,
    input  wire  signed [COORD_BITS-1:0]         coord_y,
    input  wire  signed [COORD_BITS-1:0]         coord_z,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [COORD_BITS-1:0]         point_x,
    output logic signed [COORD_BITS-1:0]         point_y,
    output logic signed [COORD_BITS-1:0]         point_z,
    output logic [$clog2(CAPACITY+1)-1:0]        entry_count
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int DIST_W  = 2 * COORD_BITS;
    localparam int ENTRY_W = 3 * COORD_BITS + DIST_W;

    pdnf_pkg::fsm_state_t state_reg;
    pdnf_pkg::fsm_state_t state_next;
    pdnf_pkg::action_t    act_in;
    pdnf_pkg::action_t    act_reg;
    pdnf_pkg::action_t    act_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] scan_next;

    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic signed [COORD_BITS-1:0] cz_reg;

    logic [DIST_W-1:0]     best_d_reg;
    logic [DIST_W-1:0]     best_d_next;
    logic [COORD_BITS-1:0] best_x_reg;
    logic [COORD_BITS-1:0] best_x_next;
    logic [COORD_BITS-1:0] best_y_reg;
    logic [COORD_BITS-1:0] best_y_next;
    logic [COORD_BITS-1:0] best_z_reg;
    logic [COORD_BITS-1:0] best_z_next;

    logic                  done_reg;
    logic                  done_next;
    pdnf_pkg::status_t     status_reg;
    pdnf_pkg::status_t     status_next;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] px_next;
    logic [COORD_BITS-1:0] py_reg;
    logic [COORD_BITS-1:0] py_next;
    logic [COORD_BITS-1:0] pz_reg;
    logic [COORD_BITS-1:0] pz_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  sq_start;
    logic                  sq_done;
    logic [DIST_W-1:0]     sq_dist;
    logic [ENTRY_W-1:0]    new_entry;
    logic [ENTRY_W-1:0]    head_e;
    logic [ENTRY_W-1:0]    tail_e;
    logic [CNT_W-1:0]      cnt_m1;
    logic [IDX_W-1:0]      tail_idx;
    logic                  scan_last;
    logic                  better;
    logic                  take;

    logic [ENTRY_W-1:0]    cell_q  [CAPACITY];
    pdnf_pkg::cell_op_t    cell_op [CAPACITY];

    assign busy      = (state_reg != pdnf_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign act_in    = pdnf_pkg::action_t'(action);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign tail_idx  = cnt_m1[IDX_W-1:0];
    assign head_e    = cell_q[0];
    assign tail_e    = cell_q[tail_idx];
    assign new_entry = {sq_dist, cz_reg, cy_reg, cx_reg};
    assign scan_last = (scan_reg == IDX_W'(CAPACITY - 1));

    assign better = (act_reg == pdnf_pkg::ACT_FARTHEST)
                    ? (head_e[ENTRY_W-1:3*COORD_BITS] > best_d_reg)
                    : (head_e[ENTRY_W-1:3*COORD_BITS] < best_d_reg);
    // The first entry seeds the search; later ones replace it only when
    // strictly better, so a tie keeps the entry nearer the front.
    assign take = (scan_reg == '0)
                  || ((CNT_W'(scan_reg) < count_reg) && better);

    pdnf_sqdist #(
        .COORD_BITS (COORD_BITS)
    ) u_sqdist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .px     (cx_reg),
        .py     (cy_reg),
        .pz     (cz_reg),
        .sum_sq (sq_dist),
        .done   (sq_done)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ENTRY_W-1:0] prev_d;
        logic [ENTRY_W-1:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = new_entry;
        end
        else
        begin : g_mid
            assign prev_d = cell_q[g-1];
        end

        // The last cell closes the ring so that a full rotation restores order.
        if (g == CAPACITY - 1)
        begin : g_last
            assign next_d = cell_q[0];
        end
        else
        begin : g_inner
            assign next_d = cell_q[g+1];
        end

        pdnf_cell #(
            .ENTRY_W (ENTRY_W)
        ) u_cell (
            .clk     (clk),
            .op      (cell_op[g]),
            .prev_in (prev_d),
            .next_in (next_d),
            .new_in  (new_entry),
            .q       (cell_q[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdnf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((act_in == pdnf_pkg::ACT_PUSH_FRONT
                         || act_in == pdnf_pkg::ACT_PUSH_BACK) && !full)
                    begin
                        state_next = pdnf_pkg::S_SQ;
                    end
                    else if ((act_in == pdnf_pkg::ACT_FARTHEST
                              || act_in == pdnf_pkg::ACT_NEAREST) && !empty)
                    begin
                        state_next = pdnf_pkg::S_SCAN;
                    end
                end
            end
            pdnf_pkg::S_SQ:
            begin
                if (sq_done)
                begin
                    state_next = pdnf_pkg::S_IDLE;
                end
            end
            pdnf_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = pdnf_pkg::S_IDLE;
                end
            end
            default: state_next = pdnf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_op[i] = pdnf_pkg::OP_HOLD;
        end
        act_next    = act_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        best_d_next = best_d_reg;
        best_x_next = best_x_reg;
        best_y_next = best_y_reg;
        best_z_next = best_z_reg;
        sq_start    = 1'b0;
        done_next   = 1'b0;
        status_next = pdnf_pkg::ST_OK;
        px_next     = '0;
        py_next     = '0;
        pz_next     = '0;

        case (state_reg)
            pdnf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next = act_in;
                    case (act_in)
                        pdnf_pkg::ACT_PUSH_FRONT, pdnf_pkg::ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                done_next   = 1'b1;
                                status_next = pdnf_pkg::ST_FULL;
                            end
                            else
                            begin
                                sq_start = 1'b1;
                            end
                        end
                        pdnf_pkg::ACT_POP_FRONT:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                status_next = pdnf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                px_next    = head_e[COORD_BITS-1:0];
                                py_next    = head_e[2*COORD_BITS-1:COORD_BITS];
                                pz_next    = head_e[3*COORD_BITS-1:2*COORD_BITS];
                                count_next = cnt_m1;
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    cell_op[i] = pdnf_pkg::OP_NEXT;
                                end
                            end
                        end
                        pdnf_pkg::ACT_POP_BACK:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                status_next = pdnf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                px_next    = tail_e[COORD_BITS-1:0];
                                py_next    = tail_e[2*COORD_BITS-1:COORD_BITS];
                                pz_next    = tail_e[3*COORD_BITS-1:2*COORD_BITS];
                                count_next = cnt_m1;
                            end
                        end
                        pdnf_pkg::ACT_COUNT:
                        begin
                            done_next = 1'b1;
                        end
                        pdnf_pkg::ACT_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        pdnf_pkg::ACT_FARTHEST, pdnf_pkg::ACT_NEAREST:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                status_next = pdnf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                scan_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            pdnf_pkg::S_SQ:
            begin
                if (sq_done)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (act_reg == pdnf_pkg::ACT_PUSH_FRONT)
                        begin
                            cell_op[i] = pdnf_pkg::OP_PREV;
                        end
                        else if (count_reg == CNT_W'(i))
                        begin
                            cell_op[i] = pdnf_pkg::OP_NEW;
                        end
                    end
                end
            end
            pdnf_pkg::S_SCAN:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    cell_op[i] = pdnf_pkg::OP_NEXT;
                end
                scan_next = scan_reg + IDX_W'(1);
                if (take)
                begin
                    best_d_next = head_e[ENTRY_W-1:3*COORD_BITS];
                    best_x_next = head_e[COORD_BITS-1:0];
                    best_y_next = head_e[2*COORD_BITS-1:COORD_BITS];
                    best_z_next = head_e[3*COORD_BITS-1:2*COORD_BITS];
                end
                if (scan_last)
                begin
                    done_next = 1'b1;
                    px_next   = best_x_next;
                    py_next   = best_y_next;
                    pz_next   = best_z_next;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdnf_pkg::S_IDLE;
            act_reg   <= pdnf_pkg::ACT_COUNT;
            count_reg <= '0;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            cz_reg <= coord_z;
        end
        best_d_reg <= best_d_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        best_z_reg <= best_z_next;
        status_reg <= status_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_z     = pz_reg;
    assign entry_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == pdnf_pkg::ST_FULL) |-> entry_count == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == pdnf_pkg::ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with entries stored");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != pdnf_pkg::ST_OK)
        |-> (point_x == '0 && point_y == '0 && point_z == '0))
        else $error("refused request returned a point");

    a_sq_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == pdnf_pkg::S_SQ)
        else $error("squared distance finished outside a push");

endmodule

`default_nettype wire
